// File: hw/rtl/afu_pkg.sv
// shared constants, types, table builder and saturation for the activation unit
package afu_pkg;

    localparam int DATA_BITS      = 16;
    localparam int FRAC_BITS      = 12;
    localparam int TABLE_SEGMENTS = 64;

    localparam int IDX_W      = $clog2(TABLE_SEGMENTS + 1);
    localparam int WIDE       = 2 * DATA_BITS + 4;
    localparam int NUM_STAGES = 5;
    localparam int DIV_STAGES = 3;
    localparam int DIV_STEP   = (FRAC_BITS + DIV_STAGES - 1) / DIV_STAGES;
    localparam int QB         = DIV_STAGES * DIV_STEP;
    localparam int DW         = DATA_BITS + FRAC_BITS + QB + 1;

    localparam logic [2:0] MODE_LINEAR   = 3'd0;
    localparam logic [2:0] MODE_SIGMOID  = 3'd1;
    localparam logic [2:0] MODE_TANH     = 3'd2;
    localparam logic [2:0] MODE_SOFTSIGN = 3'd3;
    localparam logic [2:0] MODE_SOFTPLUS = 3'd4;
    localparam logic [2:0] MODE_SWISH    = 3'd5;
    localparam logic [2:0] MODE_RELU     = 3'd6;

    localparam int TAB_SIG   = 0;
    localparam int TAB_TANH  = 1;
    localparam int TAB_SPLUS = 2;

    typedef logic signed [DATA_BITS-1:0] data_t;
    typedef logic [NUM_STAGES-1:0] stage_en_t;
    typedef data_t tab_t [0:TABLE_SEGMENTS];

    localparam longint unsigned ONE30   = 64'd1 << 30;
    localparam longint unsigned LN2_Q30 = 64'd744261118;
    localparam longint          MAX_VAL = (64'sd1 <<< (DATA_BITS - 1)) - 64'sd1;
    localparam longint          MIN_VAL = -MAX_VAL - 64'sd1;

    // clamp to the signed data range
    function automatic data_t sat_data(input logic signed [WIDE-1:0] v);
        logic signed [WIDE-1:0] hi;
        logic signed [WIDE-1:0] lo;
        hi = WIDE'(MAX_VAL);
        lo = WIDE'(MIN_VAL);
        if (v > hi) return data_t'(MAX_VAL);
        if (v < lo) return data_t'(MIN_VAL);
        return v[DATA_BITS-1:0];
    endfunction

    // unsigned shift-subtract quotient, table build only
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-a), a and result in Q30
    function automatic longint unsigned exp_neg30(input longint unsigned a);
        longint unsigned n;
        longint unsigned r;
        longint unsigned term;
        longint          sum;
        n = udiv64(a, LN2_Q30);
        if (n >= 64'd40) return 64'd0;
        r    = a - n * LN2_Q30;
        term = ONE30;
        sum  = longint'(ONE30);
        for (int k = 1; k <= 16; k++) begin
            term = udiv64(term * r, longint'(k) << 30);
            if (k[0]) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        return longint'(unsigned'(sum)) >> n;
    endfunction

    // ln(1+u) in Q30 via atanh series
    function automatic longint unsigned ln1p30(input longint unsigned u);
        longint unsigned z;
        longint unsigned z2;
        longint unsigned term;
        longint unsigned sum;
        z    = udiv64(u << 30, (ONE30 << 1) + u);
        z2   = (z * z) >> 30;
        term = z;
        sum  = z;
        for (int k = 3; k <= 41; k += 2) begin
            term = (term * z2) >> 30;
            sum  = sum + udiv64(term, longint'(k));
        end
        return sum << 1;
    endfunction

    function automatic longint q30_to_qf(input longint unsigned v);
        longint unsigned r;
        r = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (r > longint'(MAX_VAL)) return MAX_VAL;
        return longint'(r);
    endfunction

    function automatic data_t sat_long(input longint v);
        if (v > MAX_VAL) return data_t'(MAX_VAL);
        if (v < MIN_VAL) return data_t'(MIN_VAL);
        return data_t'(v);
    endfunction

    // knot values, evaluated at elaboration
    function automatic tab_t build_tab(input int sel);
        tab_t            tab;
        longint          p;
        logic            neg;
        logic            big;
        longint unsigned mag;
        longint unsigned a;
        longint unsigned e;
        longint unsigned s;
        longint unsigned e2;
        longint unsigned t;
        longint          tq;
        for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
            p   = longint'(k) * (64'sd1 <<< DATA_BITS)
                - (longint'(TABLE_SEGMENTS) <<< (DATA_BITS - 1));
            neg = p < 0;
            mag = neg ? longint'(-p) : longint'(p);
            big = mag >= (longint'(TABLE_SEGMENTS) << (FRAC_BITS + 6));
            a   = big ? (64'd64 << 30)
                      : (mag * (64'd1 << (30 - FRAC_BITS))) / TABLE_SEGMENTS;
            case (sel)
                TAB_SIG: begin
                    e = exp_neg30(a);
                    s = udiv64(ONE30 << 30, ONE30 + e);
                    tab[k] = sat_long(q30_to_qf(neg ? ONE30 - s : s));
                end
                TAB_TANH: begin
                    e2 = exp_neg30(a << 1);
                    t  = udiv64((ONE30 - e2) << 30, ONE30 + e2);
                    tq = q30_to_qf(t);
                    tab[k] = sat_long(neg ? -tq : tq);
                end
                default: begin
                    e = exp_neg30(a);
                    if (big) tab[k] = neg ? '0 : sat_long(longint'(mag / TABLE_SEGMENTS));
                    else tab[k] = sat_long(q30_to_qf((neg ? 64'd0 : a) + ln1p30(e)));
                end
            endcase
        end
        return tab;
    endfunction

    localparam tab_t SIG_TAB   = build_tab(TAB_SIG);
    localparam tab_t TANH_TAB  = build_tab(TAB_TANH);
    localparam tab_t SPLUS_TAB = build_tab(TAB_SPLUS);

endpackage

// File: hw/rtl/activation_function_unit_core.sv
// top level of the activation function unit
//
// one signed Q4.12 request in on s_valid/s_ready (s_sample_in), one result out
// on m_valid/m_ready (m_sample_out), same format, saturated to 16 bits
// mode_we/mode_wdata write the function select: linear, sigmoid, tanh,
// softsign, softplus, swish, relu; code 7 behaves as linear
// throughput is one request per cycle while m_ready stays high, set by
// a five-stage pipeline: table read, interpolation multiply,
// interpolation add, swish multiply, result select, with the softsign
// divider running as three stages alongside
// each stage advances whenever it is empty or the next stage advances, so a
// stalled receiver fills the pipeline bubble by bubble and s_ready drops only
// once all stages hold a request; nothing is lost or repeated
// reset (aresetn low, synchronous) clears the valid bits and sets mode to
// linear; the tables are constant logic and need no load
module activation_function_unit_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   mode_we,
    input  logic [2:0]             mode_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [afu_pkg::DATA_BITS-1:0] s_sample_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [afu_pkg::DATA_BITS-1:0] m_sample_out
);
    import afu_pkg::*;

    logic [2:0]                mode_reg;
    logic [NUM_STAGES-1:0]     valid_reg;
    stage_en_t                 stage_en;

    // per-stage payload
    data_t      x_reg [4];
    logic [2:0] md_reg [4];
    data_t      lut3_reg;
    logic signed [WIDE-1:0] swp_reg;
    data_t      out_reg;

    data_t             lut_val;
    logic [QB-1:0]     quot;
    logic              quot_neg;
    data_t             y_next;
    logic signed [WIDE-1:0] swp_next;
    logic signed [WIDE-1:0] ss_val;

    // mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_LINEAR;
        end else if (mode_we) begin
            mode_reg <= mode_wdata;
        end
    end

    // stage advances when empty or when the stage after it advances
    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_ready = stage_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) valid_reg[0] <= s_valid;
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // sample and mode ride along with the request
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            x_reg[0]  <= s_sample_in;
            md_reg[0] <= mode_reg;
        end
        for (int k = 1; k < 4; k++) begin
            if (stage_en[k]) begin
                x_reg[k]  <= x_reg[k-1];
                md_reg[k] <= md_reg[k-1];
            end
        end
    end

    afu_lut u_lut (
        .aclk     (aclk),
        .stage_en (stage_en),
        .sample   (s_sample_in),
        .mode     (mode_reg),
        .lut_val  (lut_val)
    );

    afu_div u_div (
        .aclk     (aclk),
        .stage_en (stage_en),
        .sample   (x_reg[0]),
        .quot     (quot),
        .quot_neg (quot_neg)
    );

    // swish: x * sigmoid(x) plus half an lsb before the final shift
    assign swp_next = WIDE'(x_reg[2]) * WIDE'(lut_val)
                    + (WIDE'(1) <<< (FRAC_BITS - 1));

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            lut3_reg <= lut_val;
            swp_reg  <= swp_next;
        end
    end

    // result select
    always_comb begin
        ss_val = quot_neg ? -WIDE'(quot) : WIDE'(quot);
        case (md_reg[3])
            MODE_SIGMOID, MODE_TANH, MODE_SOFTPLUS: y_next = lut3_reg;
            MODE_SOFTSIGN: y_next = sat_data(ss_val);
            MODE_SWISH:    y_next = sat_data(swp_reg >>> FRAC_BITS);
            MODE_RELU:     y_next = (x_reg[3] > 0) ? x_reg[3] : '0;
            default:       y_next = x_reg[3];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            out_reg <= y_next;
        end
    end

    assign m_valid      = valid_reg[NUM_STAGES-1];
    assign m_sample_out = out_reg;

endmodule

// File: hw/rtl/afu_lut.sv
// piecewise-linear table lookup and interpolation, three stages
module afu_lut (
    input  logic                aclk,
    input  afu_pkg::stage_en_t  stage_en,
    input  afu_pkg::data_t      sample,
    input  logic [2:0]          mode,
    output afu_pkg::data_t      lut_val
);
    import afu_pkg::*;

    localparam int TW = DATA_BITS + IDX_W;

    logic [DATA_BITS-1:0] pos;
    logic [TW-1:0]        t;
    logic [IDX_W-1:0]     idx;
    data_t                y0_next, y1_next;

    data_t                y0_reg, y1_reg, y0_s1_reg;
    logic [DATA_BITS-1:0] frac_reg;
    logic signed [2*DATA_BITS+1:0] prod_reg;
    data_t                lut_reg;

    logic signed [DATA_BITS:0]     diff;
    logic signed [2*DATA_BITS+1:0] prod_next;
    logic signed [WIDE-1:0]        sum;

    always_comb begin
        pos = {~sample[DATA_BITS-1], sample[DATA_BITS-2:0]};
        t   = TW'(pos) * TW'(TABLE_SEGMENTS);
        idx = t[TW-1:DATA_BITS];
        if (idx > IDX_W'(TABLE_SEGMENTS - 1)) idx = IDX_W'(TABLE_SEGMENTS - 1);
        case (mode)
            MODE_TANH: begin
                y0_next = TANH_TAB[idx];
                y1_next = TANH_TAB[idx + IDX_W'(1)];
            end
            MODE_SOFTPLUS: begin
                y0_next = SPLUS_TAB[idx];
                y1_next = SPLUS_TAB[idx + IDX_W'(1)];
            end
            default: begin
                y0_next = SIG_TAB[idx];
                y1_next = SIG_TAB[idx + IDX_W'(1)];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            y0_reg   <= y0_next;
            y1_reg   <= y1_next;
            frac_reg <= t[DATA_BITS-1:0];
        end
    end

    always_comb begin
        diff      = (DATA_BITS+1)'(y1_reg) - (DATA_BITS+1)'(y0_reg);
        prod_next = (2*DATA_BITS+2)'(diff) * $signed((2*DATA_BITS+2)'({1'b0, frac_reg}));
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            prod_reg  <= prod_next;
            y0_s1_reg <= y0_reg;
        end
    end

    // floor of the scaled step via arithmetic shift
    assign sum = WIDE'(y0_s1_reg) + WIDE'(prod_reg >>> DATA_BITS);

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            lut_reg <= sat_data(sum);
        end
    end

    assign lut_val = lut_reg;

endmodule

// File: hw/rtl/afu_div.sv
// pipelined restoring divider for softsign magnitude
module afu_div (
    input  logic                aclk,
    input  afu_pkg::stage_en_t  stage_en,
    input  afu_pkg::data_t      sample,
    output logic [afu_pkg::QB-1:0] quot,
    output logic                quot_neg
);
    import afu_pkg::*;

    logic [DW-1:0] rem_reg [DIV_STAGES];
    logic [DW-1:0] den_reg [DIV_STAGES];
    logic [QB-1:0] q_reg   [DIV_STAGES];
    logic          neg_reg [DIV_STAGES];

    logic [DATA_BITS-1:0] ax;
    assign ax = sample[DATA_BITS-1] ? DATA_BITS'(-sample) : DATA_BITS'(sample);

    for (genvar gs = 0; gs < DIV_STAGES; gs++) begin : g_stage
        logic [DW-1:0] rem_in, den_in, rem_next;
        logic [QB-1:0] q_in, q_next;
        logic          neg_in;

        if (gs == 0) begin : g_first
            assign rem_in = DW'(ax) << FRAC_BITS;
            assign den_in = (DW'(1) << FRAC_BITS) + DW'(ax);
            assign q_in   = '0;
            assign neg_in = sample[DATA_BITS-1];
        end else begin : g_rest
            assign rem_in = rem_reg[gs-1];
            assign den_in = den_reg[gs-1];
            assign q_in   = q_reg[gs-1];
            assign neg_in = neg_reg[gs-1];
        end

        always_comb begin
            rem_next = rem_in;
            q_next   = q_in;
            for (int j = 0; j < DIV_STEP; j++) begin
                if (rem_next >= (den_in << (QB - 1 - (gs * DIV_STEP + j)))) begin
                    rem_next = rem_next - (den_in << (QB - 1 - (gs * DIV_STEP + j)));
                    q_next[QB-1-(gs*DIV_STEP+j)] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[gs+1]) begin
                rem_reg[gs] <= rem_next;
                den_reg[gs] <= den_in;
                q_reg[gs]   <= q_next;
                neg_reg[gs] <= neg_in;
            end
        end
    end

    assign quot     = q_reg[DIV_STAGES-1];
    assign quot_neg = neg_reg[DIV_STAGES-1];

endmodule
